// File: src/aesc_pkg.sv
// Types, constants and AES round helpers for the CFB-128 decrypt stream.
// No dependencies; every other file imports this package.
package aesc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH = 3'd6;

  localparam logic [1:0] MODE_AES128 = 2'd0;
  localparam logic [1:0] MODE_AES192 = 2'd1;

  localparam int RK_DEPTH = 15;
  localparam logic [3:0] RK_LAST_ADDR = 4'd14;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] num_rounds;
  } key_status_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       message_end;
    logic [3:0] pos;
  } queue_entry_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Mode 3 saturates to AES-256.
  function automatic logic [3:0] rounds_of(input logic [1:0] mode);
    logic [3:0] nr;
    case (mode)
      MODE_AES128: nr = 4'd10;
      MODE_AES192: nr = 4'd12;
      default:     nr = 4'd14;
    endcase
    return nr;
  endfunction

  // One full AES round on a state with byte i at bits [8i+7:8i].
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last,
                                             input logic [127:0] rk);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(i+4*c) +: 8] = SBOX[s[8*(i + 4*((c+i) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8];
      a1 = t[32*c+8 +: 8];
      a2 = t[32*c+16 +: 8];
      a3 = t[32*c+24 +: 8];
      x = a0 ^ a1 ^ a2 ^ a3;
      m[32*c +: 8]    = a0 ^ x ^ xtime(a0 ^ a1);
      m[32*c+8 +: 8]  = a1 ^ x ^ xtime(a1 ^ a2);
      m[32*c+16 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      m[32*c+24 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    return (last ? t : m) ^ rk;
  endfunction

endpackage

// File: src/aesc_if.sv
// Handshake channel interfaces: ciphertext in, plaintext out, register writes.
// Depends on aesc_pkg for the configuration widths.
interface aesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       message_end;
  modport source (output valid, cipher_byte, message_end, input ready);
  modport sink (input valid, cipher_byte, message_end, output ready);
endinterface

interface aesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       message_end_out;
  modport source (output valid, plain_byte, message_end_out, input ready);
  modport sink (input valid, plain_byte, message_end_out, output ready);
endinterface

interface aesc_cfg_if
  import aesc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// File: src/aesc_key_expand.sv
// Key registers, word-serial key expansion and the round-key memory.
// Depends on aesc_pkg.
module aesc_key_expand
  import aesc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_wr_t       cfg_wr,
  input  logic [3:0]    rd_addr,
  output logic [127:0]  rk_data,
  output key_status_t   status
);

  logic [1:0]   mode;
  logic [255:0] key;
  logic         busy;
  logic [5:0]   idx;
  logic [2:0]   sub;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [95:0]  row;
  logic [127:0] mem [RK_DEPTH];

  logic [3:0]  nr;
  logic [2:0]  nk_m1;
  logic [5:0]  last_idx;
  logic [31:0] prev;
  logic [31:0] back_word;
  logic [31:0] t;
  logic [31:0] word;
  logic        in_key;
  logic        key_write;

  assign nr = rounds_of(mode);
  assign last_idx = {nr, 2'b11};
  assign key_write = cfg_wr.valid && (cfg_wr.index == REG_KEY_MODE || cfg_wr.index == REG_KEY_W0
    || cfg_wr.index == REG_KEY_W1 || cfg_wr.index == REG_KEY_W2 || cfg_wr.index == REG_KEY_W3);

  always_comb begin
    case (mode)
      MODE_AES128: nk_m1 = 3'd3;
      MODE_AES192: nk_m1 = 3'd5;
      default:     nk_m1 = 3'd7;
    endcase
    in_key = idx <= {3'b000, nk_m1};
    prev = win[0];
    back_word = win[nk_m1];
    t = prev;
    if (sub == 3'd0) begin
      t = {SBOX[prev[7:0]], SBOX[prev[31:24]], SBOX[prev[23:16]],
           SBOX[prev[15:8]] ^ rcon};
    end else if (nk_m1 == 3'd7 && sub == 3'd4) begin
      t = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
    end
    word = in_key ? key[32*idx[2:0] +: 32] : (back_word ^ t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AES128;
      key <= '0;
      busy <= 1'b1;
      idx <= '0;
      sub <= '0;
      rcon <= 8'h01;
    end else begin
      if (busy) begin
        idx <= idx + 6'd1;
        sub <= (sub == nk_m1) ? 3'd0 : sub + 3'd1;
        if (!in_key && sub == 3'd0) begin
          rcon <= xtime(rcon);
        end
        if (idx == last_idx) begin
          busy <= 1'b0;
        end
      end
      // Restart on any key or mode write.
      if (key_write) begin
        busy <= 1'b1;
        idx <= '0;
        sub <= '0;
        rcon <= 8'h01;
        case (cfg_wr.index)
          REG_KEY_MODE: mode <= cfg_wr.data[1:0];
          REG_KEY_W0:   key[63:0] <= cfg_wr.data;
          REG_KEY_W1:   key[127:64] <= cfg_wr.data;
          REG_KEY_W2:   key[191:128] <= cfg_wr.data;
          REG_KEY_W3:   key[255:192] <= cfg_wr.data;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      win[0] <= word;
      for (int i = 1; i < 8; i++) begin
        win[i] <= win[i-1];
      end
      if (idx[1:0] == 2'b11) begin
        mem[idx[5:2]] <= {word, row};
      end else begin
        row[32*idx[1:0] +: 32] <= word;
      end
    end
    rk_data <= mem[rd_addr];
  end

  assign status.busy = busy;
  assign status.num_rounds = nr;

endmodule

// File: src/aesc_front.sv
// Input side: accepts ciphertext bytes, tags each with its block position
// and queues them for the back end. Depends on aesc_pkg and aesc_if.
module aesc_front
  import aesc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  aesc_in_if.sink       stream_in,
  input  cfg_wr_t       cfg_wr,
  input  key_status_t   key_status,
  input  logic          pop,
  output logic          head_valid,
  output queue_entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  queue_entry_t   q [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [3:0]       pos;
  logic             push;

  // Hold off input while round keys are being rebuilt.
  assign stream_in.ready = (count != FULL_CNT) && !key_status.busy;
  assign push = stream_in.valid && stream_in.ready;
  assign head_valid = count != '0;
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      pos <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
        pos <= pos + 4'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
      if (cfg_wr.valid && (cfg_wr.index == REG_IV_LOW || cfg_wr.index == REG_IV_HIGH)) begin
        pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cipher_byte: stream_in.cipher_byte,
                     message_end: stream_in.message_end, pos: pos};
    end
  end

endmodule

// File: src/aesc_back.sv
// Back end: feedback register, one AES round per cycle, byte XOR and the
// output register. Depends on aesc_pkg and aesc_if.
module aesc_back
  import aesc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_wr_t       cfg_wr,
  input  key_status_t   key_status,
  input  logic          head_valid,
  input  queue_entry_t  head,
  output logic          pop,
  output logic [3:0]    rd_addr,
  input  logic [127:0]  rk_data,
  aesc_out_if.source    stream_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;

  logic [1:0]   state;
  logic [127:0] fb;
  logic [127:0] st;
  logic [3:0]   rnd;
  logic         ks_done;
  logic [63:0]  iv_low;
  logic [63:0]  iv_high;
  logic         out_valid;
  logic [7:0]   out_plain;
  logic         out_end;

  logic         out_free;
  logic         need_block;
  logic         last_round;
  logic [127:0] round_out;
  logic         iv_write;

  assign out_free = !out_valid || stream_out.ready;
  assign need_block = head.pos == 4'd0 && !ks_done;
  assign pop = state == S_IDLE && head_valid && out_free && !need_block;
  assign last_round = rnd == key_status.num_rounds;
  assign round_out = aes_round(st, last_round, rk_data);
  assign iv_write = cfg_wr.valid && (cfg_wr.index == REG_IV_LOW || cfg_wr.index == REG_IV_HIGH);

  // Address the key for the next state; the key memory registers its read data.
  always_comb begin
    case (state)
      S_INIT:  rd_addr = 4'd1;
      S_ROUND: rd_addr = (rnd == RK_LAST_ADDR) ? rnd : rnd + 4'd1;
      default: rd_addr = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ks_done <= 1'b0;
      out_valid <= 1'b0;
      fb <= '0;
      iv_low <= '0;
      iv_high <= '0;
      rnd <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (head_valid && need_block) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          st <= fb ^ rk_data;
          rnd <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (last_round) begin
            fb <= round_out;
            ks_done <= 1'b1;
            state <= S_IDLE;
          end else begin
            st <= round_out;
            rnd <= rnd + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (pop) begin
        out_valid <= 1'b1;
        out_plain <= fb[8*head.pos +: 8] ^ head.cipher_byte;
        out_end <= head.message_end;
        fb[8*head.pos +: 8] <= head.cipher_byte;
        ks_done <= 1'b0;
      end else if (stream_out.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr.valid && cfg_wr.index == REG_IV_LOW) begin
        iv_low <= cfg_wr.data;
        fb <= {iv_high, cfg_wr.data};
      end
      if (cfg_wr.valid && cfg_wr.index == REG_IV_HIGH) begin
        iv_high <= cfg_wr.data;
        fb <= {cfg_wr.data, iv_low};
      end
      if (iv_write) begin
        ks_done <= 1'b0;
      end
    end
  end

  assign stream_out.valid = out_valid;
  assign stream_out.plain_byte = out_plain;
  assign stream_out.message_end_out = out_end;

endmodule

// File: src/aes_cfb128_decrypt_stream_top.sv
// Channel     Role    Payload
// stream_in   sink    cipher_byte[7:0], message_end
// stream_out  source  plain_byte[7:0], message_end_out
// cfg         sink    reg_index[2:0], reg_data[63:0]
//
// A 16-byte block goes through a start step, the initial key add, one AES round per
// cycle for Nr = 10, 12 or 14 rounds, and then the XOR of each of its bytes.
// Reset and every key or mode write rebuild the round keys, one word per
// cycle; input is held off meanwhile. cfg is always ready.
// The queue lets input arrive during a block encryption; the output register
// holds a byte until taken.
// Depends on aesc_pkg, aesc_if and the aesc_* submodules.
module aes_cfb128_decrypt_stream_top
  import aesc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  aesc_in_if.sink    stream_in,
  aesc_out_if.source stream_out,
  aesc_cfg_if.sink   cfg
);

  cfg_wr_t      cfg_wr;
  key_status_t  key_status;
  logic         pop;
  logic         head_valid;
  queue_entry_t head;
  logic [3:0]   rd_addr;
  logic [127:0] rk_data;

  assign cfg.ready = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.index = cfg.reg_index;
  assign cfg_wr.data = cfg.reg_data;

  aesc_key_expand u_key (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .rd_addr(rd_addr),
    .rk_data(rk_data), .status(key_status)
  );

  aesc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .stream_in(stream_in), .cfg_wr(cfg_wr),
    .key_status(key_status), .pop(pop), .head_valid(head_valid), .head(head)
  );

  aesc_back u_back (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .key_status(key_status),
    .head_valid(head_valid), .head(head), .pop(pop), .rd_addr(rd_addr),
    .rk_data(rk_data), .stream_out(stream_out)
  );

endmodule
